[sv/fcs_pkg.sv]
// Shared types, constants and codes of the FABRIK chain solver.
package fcs_pkg;

    localparam int MAX_JOINTS_DEF = 16;
    localparam int COORD_W        = 32;
    localparam int CFG_W          = 31;
    localparam int CFG_IDX_W      = 3;
    localparam int JIDX_W         = 4;
    localparam int ITER_W         = 8;
    localparam int STIFF_W        = 17;
    localparam logic [STIFF_W-1:0] STIFF_ONE = 17'd65536;
    localparam int SQ_W           = 64;
    localparam int ROOT_W         = 32;
    localparam int NUM_W          = 64;
    localparam int DEN_W          = 32;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_COUNT  = 3'd1,
        CFG_ITER   = 3'd2,
        CFG_TOL    = 3'd3,
        CFG_STIFF  = 3'd4
    } t_cfg_idx;

    // Input item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SOLVE = 1'b1;

    typedef struct packed {
        logic   func;
        t_coord pos_x;
        t_coord pos_y;
        t_coord pos_z;
    } t_in_item;

    typedef struct packed {
        logic [JIDX_W-1:0] joint_index;
        t_coord            out_x;
        t_coord            out_y;
        t_coord            out_z;
        logic              converged;
        logic              last;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_CP_RD, S_CP_WR, S_FA, S_FB, S_FC, S_RED,
        S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_SQS, S_SQW, S_AFTER,
        S_PM, S_PD, S_PW, S_PWR, S_IT, S_RT_RD, S_RT_WR,
        S_OUT_RD, S_OUT_CAP, S_BM, S_BA, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_SEG, PH_BACK, PH_FWD, PH_CHK
    } t_phase;

endpackage

[sv/fcs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/fcs_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
module fcs_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fcs_pkg::SQ_W-1:0]    i_val,
    output logic                        o_done,
    output logic [fcs_pkg::ROOT_W-1:0]  o_root
);

    localparam int CNT_W = $clog2(fcs_pkg::ROOT_W);

    logic                       r_busy;
    logic [CNT_W-1:0]           r_cnt;
    logic [fcs_pkg::SQ_W-1:0]   r_v;
    logic [fcs_pkg::ROOT_W+1:0] r_rem;
    logic [fcs_pkg::ROOT_W-1:0] r_root;
    logic [fcs_pkg::ROOT_W+3:0] w_rem2;
    logic [fcs_pkg::ROOT_W+3:0] w_trial;
    logic                       w_ge;

    assign w_rem2  = {r_rem, r_v[fcs_pkg::SQ_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v    <= {r_v[fcs_pkg::SQ_W-3:0], 2'b00};
                r_rem  <= w_ge ? (fcs_pkg::ROOT_W+2)'(w_rem2 - w_trial)
                               : (fcs_pkg::ROOT_W+2)'(w_rem2);
                r_root <= {r_root[fcs_pkg::ROOT_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(fcs_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

[sv/fcs_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module fcs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fcs_pkg::NUM_W-1:0]  i_num,
    input  logic [fcs_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [fcs_pkg::NUM_W-1:0]  o_quo
);

    localparam int CNT_W = $clog2(fcs_pkg::NUM_W);

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic [fcs_pkg::NUM_W-1:0] r_num;
    logic [fcs_pkg::DEN_W-1:0] r_den;
    logic [fcs_pkg::DEN_W-1:0] r_rem;
    logic [fcs_pkg::DEN_W:0]   w_rem2;
    logic                      w_ge;

    assign w_rem2 = {r_rem, r_num[fcs_pkg::NUM_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign o_quo  = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                // The numerator register fills with quotient bits from the bottom.
                r_rem  <= w_ge ? fcs_pkg::DEN_W'(w_rem2 - {1'b0, r_den})
                               : fcs_pkg::DEN_W'(w_rem2);
                r_num  <= {r_num[fcs_pkg::NUM_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(fcs_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

[sv/fabrik_chain_solver.sv]
// FABRIK chain solver top level: sequencer, shared multiplier and joint memories.
// A load transfer gives no result; loads may come every cycle.
// A solve keeps busy high for the whole run, mostly waiting on the divides.
// Results leave one per joint, one cycle each; the receiver cannot stall.
// Synchronous active-low reset clears control and configuration; memories keep data.
module fabrik_chain_solver #(
    parameter int MAX_JOINTS = fcs_pkg::MAX_JOINTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fcs_pkg::t_in_item                i_item,
    output logic                             o_strobe,
    output fcs_pkg::t_out_item               o_result,
    input  logic                             i_cfg_we,
    input  logic [fcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fcs_pkg::CFG_W-1:0]        i_cfg_data
);

    // Address width of the joint memories and width of a joint count.
    localparam int AW = $clog2(MAX_JOINTS);
    localparam int CW = $clog2(MAX_JOINTS + 1);
    localparam int CO = fcs_pkg::COORD_W;
    localparam int PW = 3 * CO;
    localparam logic signed [67:0] C_MAX = 68'sd2147483647;
    localparam logic signed [67:0] C_MIN = -68'sd2147483648;

    // Clamp a wide signed value into the coordinate range.
    function automatic fcs_pkg::t_coord sat_c(input logic signed [67:0] v);
        fcs_pkg::t_coord res;
        if (v > C_MAX) begin
            res = C_MAX[CO-1:0];
        end else if (v < C_MIN) begin
            res = C_MIN[CO-1:0];
        end else begin
            res = v[CO-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic                          r_en;
    logic [4:0]                    r_jc;
    logic [fcs_pkg::ITER_W-1:0]    r_itl;
    logic [fcs_pkg::CFG_W-1:0]     r_tol;
    logic [fcs_pkg::STIFF_W-1:0]   r_stf;

    // Sequencer state.
    fcs_pkg::t_state               r_state, n_state;
    fcs_pkg::t_phase               r_ph;
    logic [CW-1:0]                 r_lp;
    logic [CW-1:0]                 r_n;
    logic [AW-1:0]                 r_i;
    logic [fcs_pkg::ITER_W-1:0]    r_it;
    logic [1:0]                    r_k;
    logic                          r_conv;
    logic                          r_solve;

    // Datapath registers.
    fcs_pkg::t_coord               r_tgt [3];
    fcs_pkg::t_coord               r_pa  [3];
    fcs_pkg::t_coord               r_pb  [3];
    fcs_pkg::t_coord               r_res [3];
    logic [30:0]                   r_m   [3];
    logic                          r_neg [3];
    logic [1:0]                    r_sh;
    logic [31:0]                   r_len;
    logic [fcs_pkg::SQ_W-1:0]      r_acc;
    logic signed [67:0]            r_prod;
    logic [fcs_pkg::ROOT_W-1:0]    r_l;
    logic                          r_strobe;
    fcs_pkg::t_out_item            r_out;

    // Memory ports.
    logic          st_we, wk_we, sg_we;
    logic [AW-1:0] st_waddr, st_raddr, wk_waddr, wk_raddr, sg_waddr, sg_raddr;
    logic [PW-1:0] st_wdata, st_rdata, wk_wdata, wk_rdata;
    logic [31:0]   sg_wdata, sg_rdata;

    // Combinational helpers.
    logic [CW-1:0]           w_n;
    logic                    w_solve;
    logic [AW-1:0]           w_nm1, w_ip1, w_ia, w_ib, w_iw;
    fcs_pkg::t_coord         w_st_pt [3];
    fcs_pkg::t_coord         w_wk_pt [3];
    logic [32:0]             w_mag   [3];
    logic signed [32:0]      w_dif   [3];
    logic [1:0]              w_sh;
    logic [33:0]             w_d;
    logic signed [33:0]      w_ma, w_mb;
    logic signed [33:0]      w_bdif;
    logic                    w_sq_start, w_sq_done, w_dv_start, w_dv_done;
    logic [fcs_pkg::ROOT_W-1:0] w_root;
    logic [fcs_pkg::NUM_W-1:0]  w_quo;
    logic signed [67:0]      w_qs, w_place, w_blend;
    logic [fcs_pkg::STIFF_W-1:0] w_st;

    assign busy     = (r_state != fcs_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // The joint count is clamped to the memory depth; a chain of one joint is passed through.
    assign w_n     = (32'(r_jc) > MAX_JOINTS) ? CW'(MAX_JOINTS) : CW'(r_jc);
    assign w_solve = r_en && (w_n >= CW'(2));
    assign w_nm1   = AW'(r_n - 1'b1);
    assign w_ip1   = r_i + 1'b1;
    assign w_st    = (r_stf > fcs_pkg::STIFF_ONE) ? fcs_pkg::STIFF_ONE : r_stf;

    // The phase picks the anchor, the point it reaches toward and the entry written back.
    always_comb begin
        w_ia = r_i;
        w_ib = w_ip1;
        w_iw = w_ip1;
        case (r_ph)
            fcs_pkg::PH_SEG: begin
                w_ia = r_i;
                w_ib = w_ip1;
            end
            fcs_pkg::PH_BACK: begin
                w_ia = w_ip1;
                w_ib = r_i;
                w_iw = r_i;
            end
            fcs_pkg::PH_FWD: begin
                w_ia = r_i;
                w_ib = w_ip1;
                w_iw = w_ip1;
            end
            fcs_pkg::PH_CHK: begin
                w_ia = w_nm1;
            end
            default: begin
                w_ia = r_i;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_st_pt[k] = st_rdata[PW-1-CO*k -: CO];
            w_wk_pt[k] = wk_rdata[PW-1-CO*k -: CO];
        end
    end

    // Difference reduction: all three components are shifted right together
    // until each magnitude fits in 31 bits.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dif[k] = 33'(r_pb[k]) - 33'(r_pa[k]);
            w_mag[k] = w_dif[k][32] ? 33'(-w_dif[k]) : 33'(w_dif[k]);
        end
        if (w_mag[0][32] || w_mag[1][32] || w_mag[2][32]) begin
            w_sh = 2'd2;
        end else if (w_mag[0][31] || w_mag[1][31] || w_mag[2][31]) begin
            w_sh = 2'd1;
        end else begin
            w_sh = 2'd0;
        end
    end

    assign w_d = {2'b00, r_l} << r_sh;

    // Placement: anchor plus or minus the scaled step; blend: stored plus rounded weighted move.
    assign w_qs    = r_neg[r_k] ? -68'sd0 - $signed({4'b0000, w_quo})
                                : $signed({4'b0000, w_quo});
    assign w_place = 68'(r_pa[r_k]) + w_qs;
    assign w_blend = 68'(r_pa[r_k]) + ((r_prod + 68'sd32768) >>> 16);
    assign w_bdif  = 34'(r_pb[r_k]) - 34'(r_pa[r_k]);

    // One shared multiplier serves the squares, the placement scale and the blend.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            fcs_pkg::S_SQ0: begin
                w_ma = $signed({3'b000, r_m[0]});
                w_mb = $signed({3'b000, r_m[0]});
            end
            fcs_pkg::S_SQ1: begin
                w_ma = $signed({3'b000, r_m[1]});
                w_mb = $signed({3'b000, r_m[1]});
            end
            fcs_pkg::S_SQ2: begin
                w_ma = $signed({3'b000, r_m[2]});
                w_mb = $signed({3'b000, r_m[2]});
            end
            fcs_pkg::S_PM: begin
                w_ma = $signed({3'b000, r_m[r_k]});
                w_mb = $signed({2'b00, r_len});
            end
            fcs_pkg::S_BM: begin
                w_ma = w_bdif;
                w_mb = $signed({17'd0, w_st});
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end

    assign w_sq_start = (r_state == fcs_pkg::S_SQS);
    assign w_dv_start = (r_state == fcs_pkg::S_PD) && (r_l != '0);

    // Next state and memory control.
    always_comb begin
        n_state  = r_state;
        st_we    = 1'b0;
        st_waddr = AW'(r_lp);
        st_wdata = {i_item.pos_x, i_item.pos_y, i_item.pos_z};
        st_raddr = r_i;
        wk_we    = 1'b0;
        wk_waddr = w_iw;
        wk_wdata = {r_res[0], r_res[1], r_res[2]};
        wk_raddr = w_ia;
        sg_we    = 1'b0;
        sg_waddr = r_i;
        sg_wdata = (w_d[33:32] != 2'b00) ? 32'hFFFF_FFFF : w_d[31:0];
        sg_raddr = r_i;
        case (r_state)
            fcs_pkg::S_IDLE: begin
                if (start) begin
                    if (i_item.func == fcs_pkg::FUNC_LOAD) begin
                        st_we = (32'(r_lp) < MAX_JOINTS);
                    end else if (w_n != '0) begin
                        n_state = w_solve ? fcs_pkg::S_CP_RD : fcs_pkg::S_OUT_RD;
                    end
                end
            end
            fcs_pkg::S_CP_RD: n_state = fcs_pkg::S_CP_WR;
            fcs_pkg::S_CP_WR: begin
                wk_we    = 1'b1;
                wk_waddr = r_i;
                wk_wdata = st_rdata;
                n_state  = (r_i == w_nm1) ? fcs_pkg::S_FA : fcs_pkg::S_CP_RD;
            end
            fcs_pkg::S_FA: n_state = fcs_pkg::S_FB;
            fcs_pkg::S_FB: begin
                wk_raddr = w_ib;
                n_state  = fcs_pkg::S_FC;
            end
            fcs_pkg::S_FC:  n_state = fcs_pkg::S_RED;
            fcs_pkg::S_RED: n_state = fcs_pkg::S_SQ0;
            fcs_pkg::S_SQ0: n_state = fcs_pkg::S_SQ1;
            fcs_pkg::S_SQ1: n_state = fcs_pkg::S_SQ2;
            fcs_pkg::S_SQ2: n_state = fcs_pkg::S_SQ3;
            fcs_pkg::S_SQ3: n_state = fcs_pkg::S_SQS;
            fcs_pkg::S_SQS: n_state = fcs_pkg::S_SQW;
            fcs_pkg::S_SQW: begin
                if (w_sq_done) begin
                    n_state = fcs_pkg::S_AFTER;
                end
            end
            fcs_pkg::S_AFTER: begin
                case (r_ph)
                    fcs_pkg::PH_SEG: begin
                        sg_we   = 1'b1;
                        n_state = (w_ip1 == w_nm1) ? fcs_pkg::S_IT : fcs_pkg::S_FA;
                    end
                    fcs_pkg::PH_CHK: begin
                        n_state = (w_d < {3'b000, r_tol}) ? fcs_pkg::S_OUT_RD
                                                          : fcs_pkg::S_IT;
                    end
                    default: n_state = fcs_pkg::S_PM;
                endcase
            end
            fcs_pkg::S_PM: n_state = fcs_pkg::S_PD;
            fcs_pkg::S_PD: begin
                if (r_l != '0) begin
                    n_state = fcs_pkg::S_PW;
                end else begin
                    n_state = (r_k == 2'd2) ? fcs_pkg::S_PWR : fcs_pkg::S_PM;
                end
            end
            fcs_pkg::S_PW: begin
                if (w_dv_done) begin
                    n_state = (r_k == 2'd2) ? fcs_pkg::S_PWR : fcs_pkg::S_PM;
                end
            end
            fcs_pkg::S_PWR: begin
                wk_we = 1'b1;
                if (r_ph == fcs_pkg::PH_BACK && r_i == '0) begin
                    n_state = fcs_pkg::S_RT_RD;
                end else begin
                    n_state = fcs_pkg::S_FA;
                end
            end
            fcs_pkg::S_IT: begin
                if (r_it == r_itl) begin
                    n_state = fcs_pkg::S_OUT_RD;
                end else begin
                    // Pin the end joint to the target before reaching back.
                    wk_we    = 1'b1;
                    wk_waddr = w_nm1;
                    wk_wdata = {r_tgt[0], r_tgt[1], r_tgt[2]};
                    n_state  = fcs_pkg::S_FA;
                end
            end
            fcs_pkg::S_RT_RD: begin
                st_raddr = '0;
                n_state  = fcs_pkg::S_RT_WR;
            end
            fcs_pkg::S_RT_WR: begin
                wk_we    = 1'b1;
                wk_waddr = '0;
                wk_wdata = st_rdata;
                n_state  = fcs_pkg::S_FA;
            end
            fcs_pkg::S_OUT_RD: begin
                wk_raddr = r_i;
                n_state  = fcs_pkg::S_OUT_CAP;
            end
            fcs_pkg::S_OUT_CAP: n_state = r_solve ? fcs_pkg::S_BM : fcs_pkg::S_EMIT;
            fcs_pkg::S_BM:      n_state = fcs_pkg::S_BA;
            fcs_pkg::S_BA:      n_state = (r_k == 2'd2) ? fcs_pkg::S_EMIT : fcs_pkg::S_BM;
            fcs_pkg::S_EMIT: begin
                n_state = (r_i == w_nm1) ? fcs_pkg::S_IDLE : fcs_pkg::S_OUT_RD;
            end
            default: n_state = fcs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_jc  <= 5'd2;
            r_itl <= 8'd10;
            r_tol <= 31'd655;
            r_stf <= 17'd32768;
        end else if (i_cfg_we) begin
            case (fcs_pkg::t_cfg_idx'(i_cfg_idx))
                fcs_pkg::CFG_ENABLE: r_en  <= i_cfg_data[0];
                fcs_pkg::CFG_COUNT:  r_jc  <= i_cfg_data[4:0];
                fcs_pkg::CFG_ITER:   r_itl <= i_cfg_data[fcs_pkg::ITER_W-1:0];
                fcs_pkg::CFG_TOL:    r_tol <= i_cfg_data;
                fcs_pkg::CFG_STIFF:  r_stf <= i_cfg_data[fcs_pkg::STIFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp     <= '0;
            r_n      <= '0;
            r_i      <= '0;
            r_it     <= '0;
            r_k      <= '0;
            r_ph     <= fcs_pkg::PH_SEG;
            r_conv   <= 1'b0;
            r_solve  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                fcs_pkg::S_IDLE: begin
                    if (start) begin
                        if (i_item.func == fcs_pkg::FUNC_LOAD) begin
                            if (32'(r_lp) < MAX_JOINTS) begin
                                r_lp <= r_lp + 1'b1;
                            end
                        end else begin
                            r_lp    <= '0;
                            r_n     <= w_n;
                            r_solve <= w_solve;
                            r_i     <= '0;
                            r_it    <= '0;
                            r_conv  <= 1'b0;
                            r_ph    <= fcs_pkg::PH_SEG;
                        end
                    end
                end
                fcs_pkg::S_CP_WR: begin
                    r_i <= (r_i == w_nm1) ? '0 : w_ip1;
                end
                fcs_pkg::S_AFTER: begin
                    r_k <= '0;
                    if (r_ph == fcs_pkg::PH_SEG) begin
                        r_i <= w_ip1;
                    end else if (r_ph == fcs_pkg::PH_CHK) begin
                        if (w_d < {3'b000, r_tol}) begin
                            r_conv <= 1'b1;
                            r_i    <= '0;
                        end else begin
                            r_it <= r_it + 1'b1;
                        end
                    end
                end
                fcs_pkg::S_PD: begin
                    if (r_l == '0) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                fcs_pkg::S_PW: begin
                    if (w_dv_done) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                fcs_pkg::S_PWR: begin
                    if (r_ph == fcs_pkg::PH_BACK) begin
                        if (r_i != '0) begin
                            r_i <= r_i - 1'b1;
                        end
                    end else if (w_ip1 == w_nm1) begin
                        r_ph <= fcs_pkg::PH_CHK;
                    end else begin
                        r_i <= w_ip1;
                    end
                end
                fcs_pkg::S_IT: begin
                    if (r_it == r_itl) begin
                        r_i <= '0;
                    end else begin
                        r_ph <= fcs_pkg::PH_BACK;
                        r_i  <= AW'(r_n - CW'(2));
                    end
                end
                fcs_pkg::S_RT_WR: begin
                    r_ph <= fcs_pkg::PH_FWD;
                    r_i  <= '0;
                end
                fcs_pkg::S_OUT_CAP: r_k <= '0;
                fcs_pkg::S_BA:      r_k <= r_k + 1'b1;
                fcs_pkg::S_EMIT: begin
                    r_strobe <= 1'b1;
                    r_i      <= w_ip1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            fcs_pkg::S_IDLE: begin
                r_tgt[0] <= i_item.pos_x;
                r_tgt[1] <= i_item.pos_y;
                r_tgt[2] <= i_item.pos_z;
            end
            fcs_pkg::S_FB: r_pa <= w_wk_pt;
            fcs_pkg::S_FC: begin
                r_pb  <= (r_ph == fcs_pkg::PH_CHK) ? r_tgt : w_wk_pt;
                r_len <= sg_rdata;
            end
            fcs_pkg::S_RED: begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k]   <= 31'(w_mag[k] >> w_sh);
                    r_neg[k] <= w_dif[k][32];
                end
                r_sh  <= w_sh;
                r_acc <= '0;
            end
            fcs_pkg::S_SQ1, fcs_pkg::S_SQ2, fcs_pkg::S_SQ3: begin
                r_acc <= r_acc + r_prod[63:0];
            end
            fcs_pkg::S_SQW: begin
                if (w_sq_done) begin
                    r_l <= w_root;
                end
            end
            fcs_pkg::S_PD: begin
                if (r_l == '0) begin
                    r_res[r_k] <= r_pa[r_k];
                end
            end
            fcs_pkg::S_PW: begin
                if (w_dv_done) begin
                    r_res[r_k] <= sat_c(w_place);
                end
            end
            fcs_pkg::S_OUT_CAP: begin
                r_pa  <= w_st_pt;
                r_pb  <= w_wk_pt;
                r_res <= w_st_pt;
            end
            fcs_pkg::S_BA: r_res[r_k] <= sat_c(w_blend);
            fcs_pkg::S_EMIT: begin
                r_out.joint_index <= fcs_pkg::JIDX_W'(r_i);
                r_out.out_x       <= r_res[0];
                r_out.out_y       <= r_res[1];
                r_out.out_z       <= r_res[2];
                r_out.converged   <= r_conv;
                r_out.last        <= (r_i == w_nm1);
            end
            default: ;
        endcase
    end

    fcs_ram #(.WIDTH(PW), .DEPTH(MAX_JOINTS)) u_stored (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    fcs_ram #(.WIDTH(PW), .DEPTH(MAX_JOINTS)) u_work (
        .i_clk   (i_clk),
        .i_we    (wk_we),
        .i_waddr (wk_waddr),
        .i_wdata (wk_wdata),
        .i_raddr (wk_raddr),
        .o_rdata (wk_rdata)
    );

    fcs_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_seglen (
        .i_clk   (i_clk),
        .i_we    (sg_we),
        .i_waddr (sg_waddr),
        .i_wdata (sg_wdata),
        .i_raddr (sg_raddr),
        .o_rdata (sg_rdata)
    );

    fcs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_acc),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    fcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (r_prod[63:0]),
        .i_den   (r_l),
        .o_done  (w_dv_done),
        .o_quo   (w_quo)
    );

    // A result strobe only follows a cycle of an active run.
    a_strobe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe outside a solve run");

    // The final joint of a run returns the block to idle.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("block still busy after the final joint");

    // A run never starts with an empty chain.
    a_run_has_joints: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_n != '0))
        else $error("run in progress with no joints");

    // A load transfer below capacity advances the load pointer by one.
    a_load_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == fcs_pkg::FUNC_LOAD && 32'(r_lp) < MAX_JOINTS)
        |=> (r_lp == $past(r_lp) + 1'b1))
        else $error("load pointer did not advance");

endmodule

[sim/fcs_checker.sv]
// Transfer monitor, joint-chain predictor and result comparator for the FABRIK solver bench.
`timescale 1ns / 1ps

module fcs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  fcs_pkg::t_in_item             i_item,
    input  logic                          i_strobe,
    input  fcs_pkg::t_out_item            i_result,
    input  logic                          i_cfg_we,
    input  logic [fcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fcs_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    localparam int NJ = fcs_pkg::MAX_JOINTS_DEF;

    typedef logic [2:0][31:0] t_pt;

    t_pt                stored_pt [NJ];
    t_pt                work_pt [NJ];
    logic [31:0]        seg_len [NJ];
    int                 load_ptr;
    logic               cfg_enable;
    logic [4:0]         cfg_count;
    logic [7:0]         cfg_iter;
    logic [30:0]        cfg_tol;
    logic [16:0]        cfg_stiff;
    fcs_pkg::t_out_item joint_queue [$];

    function automatic fcs_pkg::t_coord clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return fcs_pkg::t_coord'(v);
    endfunction

    function automatic logic [63:0] sqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Length of b - a after shifting the components below 2^31; s is the shift.
    function automatic logic [63:0] span(input t_pt a, input t_pt b,
                                         output logic [2:0][63:0] m,
                                         output logic [2:0] neg, output int s);
        longint      d;
        logic [63:0] sum;
        for (int i = 0; i < 3; i++) begin
            d = longint'($signed(b[i])) - longint'($signed(a[i]));
            neg[i] = d < 0;
            m[i] = neg[i] ? 64'(-d) : 64'(d);
        end
        s = 0;
        while ((m[0] >> s) >= 64'h8000_0000 || (m[1] >> s) >= 64'h8000_0000 ||
               (m[2] >> s) >= 64'h8000_0000) s++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> s;
            sum = sum + m[i] * m[i];
        end
        return sqrt64(sum);
    endfunction

    function automatic logic [63:0] reach_len(input t_pt a, input t_pt b);
        logic [2:0][63:0] m;
        logic [2:0]       neg;
        int               s;
        logic [63:0]      l;
        l = span(a, b, m, neg, s);
        return l << s;
    endfunction

    // Point at distance len from anchor in the direction of toward.
    function automatic t_pt place_at(input t_pt anchor, input t_pt toward,
                                     input logic [31:0] len);
        logic [2:0][63:0] m;
        logic [2:0]       neg;
        int               s;
        logic [63:0]      l;
        logic [63:0]      q;
        t_pt              res;
        l = span(anchor, toward, m, neg, s);
        for (int i = 0; i < 3; i++) begin
            q = (l != 0) ? (m[i] * {32'b0, len}) / l : 64'd0;
            res[i] = clamp32(longint'($signed(anchor[i])) +
                             (neg[i] ? -longint'(q) : longint'(q)));
        end
        return res;
    endfunction

    function automatic fcs_pkg::t_coord blend(input fcs_pkg::t_coord from,
                                              input fcs_pkg::t_coord to,
                                              input logic [16:0] st);
        longint t;
        longint q;
        t = (longint'(to) - longint'(from)) * longint'(st) + 64'sd32768;
        q = (t >= 0) ? t / 65536 : -((-t + 65535) / 65536);
        return clamp32(longint'(from) + q);
    endfunction

    // Runs one solve toward tgt and queues one expected result per joint.
    task automatic predict_solve(input t_pt tgt);
        int                 n;
        logic               run;
        logic               conv;
        logic [63:0]        d;
        logic [16:0]        st;
        fcs_pkg::t_out_item r;
        n = (cfg_count > NJ) ? NJ : int'(cfg_count);
        conv = 1'b0;
        for (int i = 0; i < n; i++) work_pt[i] = stored_pt[i];
        run = cfg_enable && n >= 2;
        if (run) begin
            for (int i = 0; i + 1 < n; i++) begin
                d = reach_len(work_pt[i], work_pt[i+1]);
                seg_len[i] = (d > 64'hffff_ffff) ? 32'hffff_ffff : d[31:0];
            end
            for (int it = 0; it < int'(cfg_iter) && !conv; it++) begin
                work_pt[n-1] = tgt;
                for (int i = n - 2; i >= 0; i--)
                    work_pt[i] = place_at(work_pt[i+1], work_pt[i], seg_len[i]);
                work_pt[0] = stored_pt[0];
                for (int i = 0; i + 1 < n; i++)
                    work_pt[i+1] = place_at(work_pt[i], work_pt[i+1], seg_len[i]);
                if (reach_len(work_pt[n-1], tgt) < {33'b0, cfg_tol}) conv = 1'b1;
            end
        end
        st = (cfg_stiff > fcs_pkg::STIFF_ONE) ? fcs_pkg::STIFF_ONE : cfg_stiff;
        for (int i = 0; i < n; i++) begin
            r.joint_index = fcs_pkg::JIDX_W'(i);
            r.out_x = stored_pt[i][0];
            r.out_y = stored_pt[i][1];
            r.out_z = stored_pt[i][2];
            if (run) begin
                r.out_x = blend(stored_pt[i][0], work_pt[i][0], st);
                r.out_y = blend(stored_pt[i][1], work_pt[i][1], st);
                r.out_z = blend(stored_pt[i][2], work_pt[i][2], st);
            end
            r.converged = conv;
            r.last = (i + 1 == n);
            joint_queue.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        fcs_pkg::t_out_item want;
        t_pt                tgt;
        if (!i_rst_n) begin
            o_errors   = 0;
            load_ptr   = 0;
            cfg_enable = 1'b0;
            cfg_count  = 5'd2;
            cfg_iter   = 8'd10;
            cfg_tol    = 31'd655;
            cfg_stiff  = 17'd32768;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fcs_pkg::CFG_ENABLE: cfg_enable = i_cfg_data[0];
                    fcs_pkg::CFG_COUNT:  cfg_count  = i_cfg_data[4:0];
                    fcs_pkg::CFG_ITER:   cfg_iter   = i_cfg_data[7:0];
                    fcs_pkg::CFG_TOL:    cfg_tol    = i_cfg_data[30:0];
                    fcs_pkg::CFG_STIFF:  cfg_stiff  = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_strobe) begin
                if (joint_queue.size() == 0) begin
                    report_mismatch("unexpected result", 64'(i_result.joint_index), 64'd0);
                end else begin
                    want = joint_queue.pop_front();
                    if (i_result.joint_index !== want.joint_index)
                        report_mismatch("joint_index", 64'(i_result.joint_index),
                                        64'(want.joint_index));
                    if (i_result.out_x !== want.out_x)
                        report_mismatch("out_x", 64'(i_result.out_x), 64'(want.out_x));
                    if (i_result.out_y !== want.out_y)
                        report_mismatch("out_y", 64'(i_result.out_y), 64'(want.out_y));
                    if (i_result.out_z !== want.out_z)
                        report_mismatch("out_z", 64'(i_result.out_z), 64'(want.out_z));
                    if (i_result.converged !== want.converged)
                        report_mismatch("converged", 64'(i_result.converged),
                                        64'(want.converged));
                    if (i_result.last !== want.last)
                        report_mismatch("last", 64'(i_result.last), 64'(want.last));
                end
            end
            if (i_start && !i_busy) begin
                tgt = {i_item.pos_z, i_item.pos_y, i_item.pos_x};
                if (i_item.func == fcs_pkg::FUNC_LOAD) begin
                    if (load_ptr < NJ) begin
                        stored_pt[load_ptr] = tgt;
                        load_ptr++;
                    end
                end else begin
                    load_ptr = 0;
                    predict_solve(tgt);
                end
            end
        end
        o_pending = joint_queue.size();
    end

endmodule

[sim/fabrik_chain_solver_tb.sv]
// Top-level bench of the FABRIK chain solver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fabrik_chain_solver_tb;

    // The slowest correct gap between transfers is a two-joint solve running all
    // 255 iterations; the limit leaves ample margin.
    localparam int WATCH_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 470;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    fcs_pkg::t_in_item             item;
    logic                          strobe;
    fcs_pkg::t_out_item            result;
    logic                          cfg_we;
    logic [fcs_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [fcs_pkg::CFG_W-1:0]     cfg_data;
    int                            errors;
    int                            pending;
    int                            quiet_cycles;
    int                            sent;
    int                            idle_pct;

    fabrik_chain_solver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .o_strobe   (strobe),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fcs_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (item),
        .i_strobe   (strobe),
        .i_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // The watchdog restarts whenever a transfer happens in either direction.
    always @(posedge clk) begin
        if ((start && !busy) || strobe || !rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // One input transfer. Inputs change on the falling edge, so busy is stable
    // when we look at it, and the item is taken at the next rising edge with busy
    // low. Start stays high afterwards unless the sender decides to go idle.
    task automatic send(input logic f, input fcs_pkg::t_coord x, input fcs_pkg::t_coord y,
                        input fcs_pkg::t_coord z);
        item = '{func: f, pos_x: x, pos_y: y, pos_z: z};
        start = 1'b1;
        while (busy) @(negedge clk);
        @(negedge clk);
        sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Holds the sender off until every expected result has come and the block
    // has dropped busy, then keeps waiting in case the last item caused no
    // result at all.
    task automatic drain();
        start = 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input fcs_pkg::t_cfg_idx idx,
                             input logic [fcs_pkg::CFG_W-1:0] val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic en, input logic [4:0] cnt, input logic [7:0] iters,
                             input logic [30:0] tol, input logic [16:0] stiff);
        drain();
        write_reg(fcs_pkg::CFG_ENABLE, fcs_pkg::CFG_W'(en));
        write_reg(fcs_pkg::CFG_COUNT, fcs_pkg::CFG_W'(cnt));
        write_reg(fcs_pkg::CFG_ITER, fcs_pkg::CFG_W'(iters));
        write_reg(fcs_pkg::CFG_TOL, fcs_pkg::CFG_W'(tol));
        write_reg(fcs_pkg::CFG_STIFF, fcs_pkg::CFG_W'(stiff));
    endtask

    // Coordinates lean toward values within 32 units of the origin so that chains stay
    // solvable, with the extremes and fully random words mixed in.
    function automatic fcs_pkg::t_coord rnd_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return fcs_pkg::t_coord'($urandom);
            default: return fcs_pkg::t_coord'($urandom_range(0, 32'h0040_0000))
                            - 32'sh0020_0000;
        endcase
    endfunction

    task automatic load_rnd();
        send(fcs_pkg::FUNC_LOAD, rnd_coord(), rnd_coord(), rnd_coord());
    endtask

    task automatic solve_rnd();
        send(fcs_pkg::FUNC_SOLVE, rnd_coord(), rnd_coord(), rnd_coord());
    endtask

    initial begin
        logic [4:0]  cnt;
        logic [7:0]  iters;
        logic [30:0] tol;
        logic [16:0] stiff;
        int          n_eff;
        int          n_loads;

        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        sent = 0;
        idle_pct = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. First fill every joint along a straight line one unit
        // apart, with one joint at the extremes; the seventeenth load finds the
        // store full and must be ignored.
        for (int i = 0; i < 16; i++) begin
            if (i == 5)
                send(fcs_pkg::FUNC_LOAD, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
            else
                send(fcs_pkg::FUNC_LOAD, fcs_pkg::t_coord'(i * 65536), 32'sh0, 32'sh0);
        end
        send(fcs_pkg::FUNC_LOAD, 32'sh1234_5678, 32'sh0, 32'sh0);

        // Reset settings: solver disabled, so two joints pass through unchanged.
        send(fcs_pkg::FUNC_SOLVE, 32'sh0002_0000, 32'sh0001_0000, 32'sh0);
        write_all(1'b1, 5'd4, 8'd10, 31'd655, 17'd32768);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0001_8000, 32'sh0001_8000, 32'sh0);
        // A zero joint count gives no result; a single joint passes through.
        write_all(1'b1, 5'd0, 8'd10, 31'd655, 17'd65536);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0, 32'sh0, 32'sh0);
        write_all(1'b1, 5'd1, 8'd10, 31'd655, 17'd65536);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0001_0000, 32'sh0, 32'sh0);
        // An oversized count is clamped to the full chain.
        write_all(1'b1, 5'd31, 8'd2, 31'd0, 17'd65536);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0003_0000, 32'sh0003_0000, 32'sh0);
        // No iterations: nothing moves and converged stays low.
        write_all(1'b1, 5'd3, 8'd0, 31'd655, 17'd65536);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0001_0000, 32'sh0001_0000, 32'sh0);
        // Stiffness at zero, at full weight and above full weight.
        write_all(1'b1, 5'd3, 8'd10, 31'd655, 17'd0);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0001_0000, 32'sh0001_0000, 32'sh0);
        write_all(1'b1, 5'd3, 8'd10, 31'd655, 17'h1ffff);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0001_0000, 32'sh0001_0000, 32'sh0);
        // The largest tolerance stops after the first iteration.
        write_all(1'b1, 5'd4, 8'd10, 31'h7fff_ffff, 17'd40000);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0000_8000, 32'sh0002_0000, 32'sh0001_0000);
        // An unreachable target with zero tolerance runs all 255 iterations.
        write_all(1'b1, 5'd2, 8'd255, 31'd0, 17'd65536);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0100_0000, 32'sh0, 32'sh0);
        // Coincident joints and extreme corners in one chain.
        write_all(1'b1, 5'd4, 8'd3, 31'd100, 17'd50000);
        send(fcs_pkg::FUNC_LOAD, 32'sh0, 32'sh0, 32'sh0);
        send(fcs_pkg::FUNC_LOAD, 32'sh0, 32'sh0, 32'sh0);
        send(fcs_pkg::FUNC_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send(fcs_pkg::FUNC_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send(fcs_pkg::FUNC_SOLVE, 32'sh0, 32'sh0, 32'sh0);

        // Random part: mostly a reconfiguration, a chain load of the configured
        // length and a solve, with stray loads, overfull loads and bare solves as
        // noise. The sender idling changes over four phases.
        cnt = 5'd4;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ((sent * 4 / RANDOM_ITEMS) % 4)
                0: idle_pct = 0;
                1: idle_pct = 53;
                2: idle_pct = 0;
                default: idle_pct = 34;
            endcase
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0: cnt = 5'($urandom_range(0, 1));
                    1: cnt = 5'($urandom_range(6, 31));
                    default: cnt = 5'($urandom_range(2, 5));
                endcase
                n_eff = (cnt > 16) ? 16 : int'(cnt);
                iters = (n_eff > 5) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 4));
                case ($urandom_range(0, 4))
                    0: tol = 31'd0;
                    1: tol = 31'h7fff_ffff;
                    2: tol = 31'($urandom);
                    default: tol = 31'($urandom_range(0, 32'h0004_0000));
                endcase
                case ($urandom_range(0, 4))
                    0: stiff = 17'd0;
                    1: stiff = 17'd65536;
                    2: stiff = 17'($urandom);
                    default: stiff = 17'($urandom_range(0, 65536));
                endcase
                write_all($urandom_range(0, 7) != 0, cnt, iters, tol, stiff);
            end
            case ($urandom_range(0, 7))
                0: n_loads = 0;
                1: n_loads = $urandom_range(0, 18);
                default: n_loads = (cnt > 16) ? 16 : int'(cnt);
            endcase
            for (int i = 0; i < n_loads; i++) load_rnd();
            if ($urandom_range(0, 9) != 0) solve_rnd();
        end

        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
